/* sv/isrc_pkg.sv */
// ----------------------------------------------------------------------------
// Interval schedule range count package
// Request and result codes, datapath commands and the control/status structs
// shared between the controller and the datapath.
// ----------------------------------------------------------------------------
package isrc_pkg;

    // Width of a time value on the ports and in the jump table.
    localparam int TIME_W  = 10;
    // Width of the request and result kind fields.
    localparam int KIND_W  = 2;
    // Width of the reported interval count and its saturation value.
    localparam int COUNT_W = 11;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'h7FF;

    // Request codes.
    localparam logic [KIND_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] REQ_BUILD = 2'd1;
    localparam logic [KIND_W-1:0] REQ_QUERY = 2'd2;
    localparam logic [KIND_W-1:0] REQ_CLEAR = 2'd3;

    // Result codes.
    localparam logic [KIND_W-1:0] RES_BUILD = 2'd0;
    localparam logic [KIND_W-1:0] RES_QUERY = 2'd1;
    localparam logic [KIND_W-1:0] RES_CLEAR = 2'd2;

    // Datapath operations.
    typedef logic [3:0] t_dp_op;
    localparam t_dp_op DP_NOP       = 4'd0;
    localparam t_dp_op DP_CAPTURE   = 4'd1;
    localparam t_dp_op DP_WIPE_ALL  = 4'd2;
    localparam t_dp_op DP_WIPE_L0   = 4'd3;
    localparam t_dp_op DP_LOAD_RD   = 4'd4;
    localparam t_dp_op DP_LOAD_WR   = 4'd5;
    localparam t_dp_op DP_PFX       = 4'd6;
    localparam t_dp_op DP_PFX_DRAIN = 4'd7;
    localparam t_dp_op DP_LVL_A     = 4'd8;
    localparam t_dp_op DP_LVL_B     = 4'd9;
    localparam t_dp_op DP_LVL_W     = 4'd10;
    localparam t_dp_op DP_QRY_RD    = 4'd11;
    localparam t_dp_op DP_QRY_STEP  = 4'd12;
    localparam t_dp_op DP_EMIT      = 4'd13;

    // Command from the controller to the datapath.
    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic addr_last;
        logic lv_last;
        logic lv_zero;
    } t_dp_stat;

endpackage

/* sv/isrc_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module isrc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/isrc_ctrl.sv */
// ----------------------------------------------------------------------------
// Interval schedule range count controller
// Sequences the clearing pass, loads, the table build, queries and clears,
// and raises the result strobe.
// ----------------------------------------------------------------------------
module isrc_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [isrc_pkg::KIND_W-1:0]     i_req_type,
    input  isrc_pkg::t_dp_stat              i_stat,
    output isrc_pkg::t_dp_cmd               o_cmd,
    output logic                            o_busy,
    output logic                            o_strobe
);

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_LOAD_RD  = 4'd2;
    localparam logic [3:0] S_LOAD_WR  = 4'd3;
    localparam logic [3:0] S_PFX      = 4'd4;
    localparam logic [3:0] S_PFX_END  = 4'd5;
    localparam logic [3:0] S_LVL_A    = 4'd6;
    localparam logic [3:0] S_LVL_B    = 4'd7;
    localparam logic [3:0] S_LVL_W    = 4'd8;
    localparam logic [3:0] S_QRY_RD   = 4'd9;
    localparam logic [3:0] S_QRY_STEP = 4'd10;
    localparam logic [3:0] S_CLR      = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_strobe;
    logic       n_strobe;

    // Next state and datapath command.
    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        o_cmd.op = isrc_pkg::DP_NOP;
        case (r_state)
            S_INIT: begin
                o_cmd.op = isrc_pkg::DP_WIPE_ALL;
                if (i_stat.addr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = isrc_pkg::DP_CAPTURE;
                    case (i_req_type)
                        isrc_pkg::REQ_LOAD:  n_state = S_LOAD_RD;
                        isrc_pkg::REQ_BUILD: n_state = S_PFX;
                        isrc_pkg::REQ_QUERY: n_state = S_QRY_RD;
                        default:             n_state = S_CLR;
                    endcase
                end
            end
            S_LOAD_RD: begin
                o_cmd.op = isrc_pkg::DP_LOAD_RD;
                n_state  = S_LOAD_WR;
            end
            S_LOAD_WR: begin
                o_cmd.op = isrc_pkg::DP_LOAD_WR;
                n_state  = S_IDLE;
            end
            S_PFX: begin
                o_cmd.op = isrc_pkg::DP_PFX;
                if (i_stat.addr_last) begin
                    n_state = S_PFX_END;
                end
            end
            S_PFX_END: begin
                o_cmd.op = isrc_pkg::DP_PFX_DRAIN;
                n_state  = S_LVL_A;
            end
            S_LVL_A: begin
                o_cmd.op = isrc_pkg::DP_LVL_A;
                n_state  = S_LVL_B;
            end
            S_LVL_B: begin
                o_cmd.op = isrc_pkg::DP_LVL_B;
                n_state  = i_stat.addr_last ? S_LVL_W : S_LVL_A;
            end
            S_LVL_W: begin
                o_cmd.op = isrc_pkg::DP_LVL_W;
                n_state  = i_stat.lv_last ? S_DONE : S_LVL_A;
            end
            S_QRY_RD: begin
                o_cmd.op = isrc_pkg::DP_QRY_RD;
                n_state  = S_QRY_STEP;
            end
            S_QRY_STEP: begin
                o_cmd.op = isrc_pkg::DP_QRY_STEP;
                if (i_stat.lv_zero) begin
                    n_state = S_DONE;
                end
            end
            S_CLR: begin
                o_cmd.op = isrc_pkg::DP_WIPE_L0;
                if (i_stat.addr_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.op = isrc_pkg::DP_EMIT;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // State and strobe registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

    // A result is only ever presented right after the done state.
    a_strobe_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state == S_DONE))
        else $error("result strobe without a finished item");

    // An accepted item always takes the controller out of idle.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && i_start |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");

    // No strobe while the table is still being cleared after reset.
    a_no_strobe_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !r_strobe && o_busy)
        else $error("activity during the clearing pass");

endmodule

/* sv/isrc_dp.sv */
// ----------------------------------------------------------------------------
// Interval schedule range count datapath
// One RAM per jump level, the sweep and level counters, the query walk and
// the result registers.
// ----------------------------------------------------------------------------
module isrc_dp #(
    parameter int TIME_SLOTS  = 1024,
    parameter int JUMP_LEVELS = 11
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  isrc_pkg::t_dp_cmd                 i_cmd,
    input  logic [isrc_pkg::KIND_W-1:0]       i_req_type,
    input  logic [isrc_pkg::TIME_W-1:0]       i_start_time,
    input  logic [isrc_pkg::TIME_W-1:0]       i_end_time,
    output isrc_pkg::t_dp_stat                o_stat,
    output logic [isrc_pkg::KIND_W-1:0]       o_result_kind,
    output logic [isrc_pkg::COUNT_W-1:0]      o_interval_count
);

    localparam int AW = (TIME_SLOTS > 1) ? $clog2(TIME_SLOTS) : 1;
    localparam int LW = $clog2(JUMP_LEVELS);
    localparam int CW = JUMP_LEVELS;
    localparam int TW = isrc_pkg::TIME_W;
    localparam logic [31:0]   SLOTS32   = 32'(TIME_SLOTS);
    localparam logic [AW-1:0] ADDR_LAST = AW'(TIME_SLOTS - 1);
    localparam logic [LW-1:0] LV_TOP    = LW'(JUMP_LEVELS - 1);

    // Captured request.
    logic [isrc_pkg::KIND_W-1:0] r_kind, n_kind;
    logic [TW-1:0]               r_st, n_st;
    logic [TW-1:0]               r_en, n_en;
    logic [TW-1:0]               r_lo, n_lo;

    // Sweep, level and walk state.
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_wr_addr, n_wr_addr;
    logic          r_wr_pend, n_wr_pend;
    logic          r_mid_ok, n_mid_ok;
    logic [LW-1:0] r_lv, n_lv;
    logic [LW-1:0] r_rd_lv, n_rd_lv;
    logic [AW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_count, n_count;
    logic [TW-1:0] r_run, n_run;

    // Result payload.
    logic [isrc_pkg::KIND_W-1:0]  r_out_kind, n_out_kind;
    logic [isrc_pkg::COUNT_W-1:0] r_out_count, n_out_count;

    // RAM ports.
    logic [JUMP_LEVELS-1:0] w_we;
    logic [AW-1:0]          w_waddr;
    logic [TW-1:0]          w_wdata;
    logic [AW-1:0]          w_raddr;
    logic [TW-1:0]          w_rdata [JUMP_LEVELS];

    logic [TW-1:0]          w_rd;
    logic                   w_rd_in;
    logic [TW-1:0]          w_max;
    logic [AW-1:0]          w_addr_nxt;
    logic                   w_take;
    logic [AW-1:0]          w_new_pos;

    // One table level per RAM; all share the read and write addresses.
    for (genvar g = 0; g < JUMP_LEVELS; g++) begin : g_level
        isrc_ram #(
            .WIDTH (TW),
            .DEPTH (TIME_SLOTS),
            .AW    (AW)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[g]),
            .i_waddr (w_waddr),
            .i_wdata (w_wdata),
            .i_raddr (w_raddr),
            .o_rdata (w_rdata[g])
        );
    end

    // Read data of the level that was addressed in the previous cycle.
    assign w_rd       = w_rdata[r_rd_lv];
    assign w_rd_in    = (32'(w_rd) < SLOTS32);
    assign w_max      = (w_rd > r_run) ? w_rd : r_run;
    assign w_addr_nxt = (r_addr == ADDR_LAST) ? '0 : r_addr + AW'(1);

    // One query step: jump while the target stays inside the range.
    assign w_take    = (w_rd >= r_lo) && w_rd_in;
    assign w_new_pos = w_take ? AW'(w_rd) : r_pos;

    // Datapath operations.
    always_comb begin
        n_kind      = r_kind;
        n_st        = r_st;
        n_en        = r_en;
        n_lo        = r_lo;
        n_addr      = r_addr;
        n_wr_addr   = r_wr_addr;
        n_wr_pend   = r_wr_pend;
        n_mid_ok    = r_mid_ok;
        n_lv        = r_lv;
        n_rd_lv     = r_rd_lv;
        n_pos       = r_pos;
        n_count     = r_count;
        n_run       = r_run;
        n_out_kind  = r_out_kind;
        n_out_count = r_out_count;
        w_we        = '0;
        w_waddr     = r_addr;
        w_wdata     = '0;
        w_raddr     = r_addr;
        case (i_cmd.op)
            isrc_pkg::DP_CAPTURE: begin
                n_kind    = i_req_type;
                n_st      = i_start_time;
                n_en      = i_end_time;
                n_lo      = (i_start_time == '0) ? TW'(1) : i_start_time;
                n_pos     = (32'(i_end_time) < SLOTS32) ? AW'(i_end_time) : ADDR_LAST;
                n_count   = '0;
                n_addr    = '0;
                n_lv      = LV_TOP;
                n_run     = '0;
                n_wr_pend = 1'b0;
            end
            isrc_pkg::DP_WIPE_ALL: begin
                w_we   = '1;
                n_addr = w_addr_nxt;
            end
            isrc_pkg::DP_WIPE_L0: begin
                w_we[0] = 1'b1;
                n_addr  = w_addr_nxt;
            end
            isrc_pkg::DP_LOAD_RD: begin
                w_raddr = AW'(r_en);
                n_rd_lv = '0;
            end
            isrc_pkg::DP_LOAD_WR: begin
                w_waddr = AW'(r_en);
                w_wdata = r_st;
                if ((r_st < r_en) && (32'(r_en) < SLOTS32) && (r_st > w_rd)) begin
                    w_we[0] = 1'b1;
                end
            end
            isrc_pkg::DP_PFX: begin
                // Read slot t while slot t-1 takes the running maximum.
                n_rd_lv   = '0;
                n_addr    = w_addr_nxt;
                n_wr_addr = r_addr;
                n_wr_pend = 1'b1;
                w_waddr   = r_wr_addr;
                w_wdata   = w_max;
                if (r_wr_pend) begin
                    w_we[0] = 1'b1;
                    n_run   = w_max;
                end
            end
            isrc_pkg::DP_PFX_DRAIN: begin
                w_waddr   = r_wr_addr;
                w_wdata   = w_max;
                w_we[0]   = r_wr_pend;
                n_wr_pend = 1'b0;
                n_lv      = LW'(1);
            end
            isrc_pkg::DP_LVL_A: begin
                // Read the midpoint of slot t; finish the previous slot.
                n_rd_lv = r_lv - LW'(1);
                w_waddr = r_wr_addr;
                w_wdata = r_mid_ok ? w_rd : '0;
                if (r_wr_pend) begin
                    w_we[r_lv] = 1'b1;
                end
            end
            isrc_pkg::DP_LVL_B: begin
                // Follow the midpoint one more step on the lower level.
                w_raddr   = AW'(w_rd);
                n_mid_ok  = w_rd_in;
                n_wr_addr = r_addr;
                n_wr_pend = 1'b1;
                n_addr    = w_addr_nxt;
            end
            isrc_pkg::DP_LVL_W: begin
                w_waddr    = r_wr_addr;
                w_wdata    = r_mid_ok ? w_rd : '0;
                w_we[r_lv] = 1'b1;
                n_wr_pend  = 1'b0;
                if (r_lv != LV_TOP) begin
                    n_lv = r_lv + LW'(1);
                end
            end
            isrc_pkg::DP_QRY_RD: begin
                w_raddr = r_pos;
                n_rd_lv = r_lv;
            end
            isrc_pkg::DP_QRY_STEP: begin
                w_raddr = w_new_pos;
                n_pos   = w_new_pos;
                if (w_take) begin
                    n_count = r_count + (CW'(1) << r_lv);
                end
                if (r_lv != '0) begin
                    n_lv    = r_lv - LW'(1);
                    n_rd_lv = r_lv - LW'(1);
                end
            end
            isrc_pkg::DP_EMIT: begin
                case (r_kind)
                    isrc_pkg::REQ_BUILD: begin
                        n_out_kind  = isrc_pkg::RES_BUILD;
                        n_out_count = '0;
                    end
                    isrc_pkg::REQ_QUERY: begin
                        n_out_kind  = isrc_pkg::RES_QUERY;
                        n_out_count = (32'(r_count) > 32'(isrc_pkg::COUNT_MAX)) ?
                                      isrc_pkg::COUNT_MAX : isrc_pkg::COUNT_W'(r_count);
                    end
                    default: begin
                        n_out_kind  = isrc_pkg::RES_CLEAR;
                        n_out_count = '0;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_wr_pend <= 1'b0;
            r_lv      <= '0;
            r_rd_lv   <= '0;
        end else begin
            r_addr    <= n_addr;
            r_wr_pend <= n_wr_pend;
            r_lv      <= n_lv;
            r_rd_lv   <= n_rd_lv;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_st        <= n_st;
        r_en        <= n_en;
        r_lo        <= n_lo;
        r_wr_addr   <= n_wr_addr;
        r_mid_ok    <= n_mid_ok;
        r_pos       <= n_pos;
        r_count     <= n_count;
        r_run       <= n_run;
        r_out_kind  <= n_out_kind;
        r_out_count <= n_out_count;
    end

    assign o_stat.addr_last  = (r_addr == ADDR_LAST);
    assign o_stat.lv_last    = (r_lv == LV_TOP);
    assign o_stat.lv_zero    = (r_lv == '0);
    assign o_result_kind     = r_out_kind;
    assign o_interval_count  = r_out_count;

    // A query only reads the table.
    a_query_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == isrc_pkg::DP_QRY_STEP) |-> (w_we == '0))
        else $error("table written during a query");

    // The query count never decreases while the walk goes on.
    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == isrc_pkg::DP_QRY_STEP) |=> (r_count >= $past(r_count)))
        else $error("query count went down");

    // The lower bound of a query never stays at zero.
    a_lo_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == isrc_pkg::DP_CAPTURE) |=> (r_lo != '0))
        else $error("query lower bound is zero");

endmodule

/* sv/interval_schedule_range_count_top.sv */
// Query: one dependent level RAM read per level of JUMP_LEVELS, from accept to
// the result strobe; a new request is taken once busy falls, as the result is strobed.
// Load: no result. Clear: one slot a cycle over all TIME_SLOTS slots.
// Build: a prefix pass, then two reads per slot and level.
// Reset: synchronous; a clearing pass zeroes every level, busy high.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// Interval schedule range count top level
// Loads intervals, builds a binary-lifting jump table and answers range
// queries with the largest number of disjoint intervals.
// ----------------------------------------------------------------------------
module interval_schedule_range_count_top #(
    parameter int TIME_SLOTS  = 1024,
    parameter int JUMP_LEVELS = 11
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [isrc_pkg::KIND_W-1:0]       i_req_type,
    input  logic [isrc_pkg::TIME_W-1:0]       i_start_time,
    input  logic [isrc_pkg::TIME_W-1:0]       i_end_time,
    output logic                              o_strobe,
    output logic [isrc_pkg::KIND_W-1:0]       o_result_kind,
    output logic [isrc_pkg::COUNT_W-1:0]      o_interval_count
);

    isrc_pkg::t_dp_cmd  w_cmd;
    isrc_pkg::t_dp_stat w_stat;

    // Sequencer.
    isrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_busy     (busy),
        .o_strobe   (o_strobe)
    );

    // Jump table and query datapath.
    isrc_dp #(
        .TIME_SLOTS  (TIME_SLOTS),
        .JUMP_LEVELS (JUMP_LEVELS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_req_type       (i_req_type),
        .i_start_time     (i_start_time),
        .i_end_time       (i_end_time),
        .o_stat           (w_stat),
        .o_result_kind    (o_result_kind),
        .o_interval_count (o_interval_count)
    );

endmodule

/* sim/interval_schedule_range_count_top_tb.sv */
// ----------------------------------------------------------------------------
// Interval schedule range count testbench
// Drives load, build, query and clear requests into the block and checks each
// strobed result against a jump table kept in the testbench. A directed
// opening covers the field extremes and the corner cases. Random rounds of
// interval loads, builds and range queries with sender idling follow.
// ----------------------------------------------------------------------------
module interval_schedule_range_count_top_tb;

    localparam int TIME_SLOTS  = 1024;
    localparam int JUMP_LEVELS = 11;
    localparam int ITEM_GOAL   = 1950;
    localparam int STALL_LIMIT = 100000;
    localparam int TW          = isrc_pkg::TIME_W;
    localparam int KW          = isrc_pkg::KIND_W;
    localparam int CNTW        = isrc_pkg::COUNT_W;

    // One expected result of a build, query or clear.
    typedef struct packed {
        logic [KW-1:0]   kind;
        logic [CNTW-1:0] count;
    } t_answer;

    // Scoreboard: a private jump table plus the queue of answers still owed.
    class range_count_scoreboard;
        logic [TW-1:0] jumps [JUMP_LEVELS][TIME_SLOTS];
        t_answer       pending[$];
        int            errors;

        function new();
            int lv;
            int t;
            for (lv = 0; lv < JUMP_LEVELS; lv++) begin
                for (t = 0; t < TIME_SLOTS; t++) begin
                    jumps[lv][t] = '0;
                end
            end
            errors = 0;
        endfunction

        // Applies an accepted item to the table and queues its answer.
        function void note_request(logic [KW-1:0] kind, logic [TW-1:0] st,
                                   logic [TW-1:0] en);
            logic [TW-1:0] lo;
            logic [TW-1:0] pos;
            logic [TW-1:0] nxt;
            int            lv;
            int            t;
            int            total;
            case (kind)
                isrc_pkg::REQ_LOAD: begin
                    // Empty, reversed and zero-start intervals leave the table alone.
                    if (st < en && st > jumps[0][en]) begin
                        jumps[0][en] = st;
                    end
                end
                isrc_pkg::REQ_BUILD: begin
                    // Prefix maximum on level 0, then each level doubles the last.
                    for (t = 1; t < TIME_SLOTS; t++) begin
                        if (jumps[0][t-1] > jumps[0][t]) begin
                            jumps[0][t] = jumps[0][t-1];
                        end
                    end
                    for (lv = 1; lv < JUMP_LEVELS; lv++) begin
                        for (t = 0; t < TIME_SLOTS; t++) begin
                            jumps[lv][t] = jumps[lv-1][jumps[lv-1][t]];
                        end
                    end
                    pending.push_back('{kind: isrc_pkg::RES_BUILD, count: '0});
                end
                isrc_pkg::REQ_QUERY: begin
                    // A lower bound of zero means one, since start zero is none.
                    lo    = (st == 0) ? TW'(1) : st;
                    pos   = en;
                    total = 0;
                    for (lv = JUMP_LEVELS - 1; lv >= 0; lv--) begin
                        nxt = jumps[lv][pos];
                        if (nxt >= lo) begin
                            pos   = nxt;
                            total += 1 << lv;
                        end
                    end
                    pending.push_back('{kind: isrc_pkg::RES_QUERY,
                                        count: (total > isrc_pkg::COUNT_MAX) ?
                                               isrc_pkg::COUNT_MAX : CNTW'(total)});
                end
                default: begin
                    // Only level 0 is wiped; higher levels stay stale.
                    for (t = 0; t < TIME_SLOTS; t++) begin
                        jumps[0][t] = '0;
                    end
                    pending.push_back('{kind: isrc_pkg::RES_CLEAR, count: '0});
                end
            endcase
        endfunction

        // Compares one strobed result with the oldest owed answer.
        function void check_answer(logic [KW-1:0] kind, logic [CNTW-1:0] count);
            t_answer want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: result with none owed: kind %0d count %0d",
                         $time, kind, count);
            end else begin
                want = pending.pop_front();
                if (kind !== want.kind) begin
                    errors++;
                    $display("%0t: result kind mismatch: expected %0d actual %0d",
                             $time, want.kind, kind);
                end
                if (count !== want.count) begin
                    errors++;
                    $display("%0t: interval count mismatch: expected %0d actual %0d",
                             $time, want.count, count);
                end
            end
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    logic [KW-1:0]   i_req_type;
    logic [TW-1:0]   i_start_time;
    logic [TW-1:0]   i_end_time;
    logic            o_strobe;
    logic [KW-1:0]   o_result_kind;
    logic [CNTW-1:0] o_interval_count;

    range_count_scoreboard answer_book;
    int                    items_done   = 0;
    int                    stall_cycles = 0;

    interval_schedule_range_count_top #(
        .TIME_SLOTS (TIME_SLOTS),
        .JUMP_LEVELS(JUMP_LEVELS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_start_time    (i_start_time),
        .i_end_time      (i_end_time),
        .o_strobe        (o_strobe),
        .o_result_kind   (o_result_kind),
        .o_interval_count(o_interval_count)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Every strobe is one result; the receiver never stalls.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            answer_book.check_answer(o_result_kind, o_interval_count);
        end
    end

    // Count cycles in which neither an item nor a result moves.
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_strobe === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("** interval_schedule_range_count_top: FAILED **");
        $finish;
    end

    // Presents one item, waits for it to be taken, then maybe idles.
    task automatic send_request(input logic [KW-1:0] kind, input logic [TW-1:0] st,
                                input logic [TW-1:0] en);
        int idle_pct;
        start        <= 1'b1;
        i_req_type   <= kind;
        i_start_time <= st;
        i_end_time   <= en;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        answer_book.note_request(kind, st, en);
        items_done++;
        // Sender idling: light, then heavy, then none.
        if (items_done < ITEM_GOAL / 3) begin
            idle_pct = 18;
        end else if (items_done < 2 * ITEM_GOAL / 3) begin
            idle_pct = 70;
        end else begin
            idle_pct = 0;
        end
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // Holds the sender off until every owed answer has come back.
    task automatic await_answers();
        start <= 1'b0;
        while (answer_book.pending.size() != 0) @(posedge i_clk);
    endtask

    // Random interval: mostly well formed, tight ones for a dense table.
    task automatic pick_interval(input bit tight, output logic [TW-1:0] st,
                                 output logic [TW-1:0] en);
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (tight || r < 85) begin
            if (tight) begin
                len = $urandom_range(1, 3);
            end else begin
                r = $urandom_range(0, 99);
                len = (r < 50) ? $urandom_range(1, 4) :
                      (r < 80) ? $urandom_range(1, 40) : $urandom_range(1, 1022);
            end
            en = TW'($urandom_range(len + 1, TIME_SLOTS - 1));
            st = en - TW'(len);
        end else if (r < 93) begin
            // Empty or reversed interval.
            en = TW'($urandom);
            st = TW'($urandom_range(en, TIME_SLOTS - 1));
        end else begin
            st = '0;
            en = TW'($urandom);
        end
    endtask

    // Random query range: whole line, ordered ranges and arbitrary bounds.
    task automatic pick_query(output logic [TW-1:0] lo, output logic [TW-1:0] hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            lo = TW'($urandom_range(0, 1));
            hi = TW'(TIME_SLOTS - 1);
        end else if (r < 85) begin
            lo = TW'($urandom_range(0, TIME_SLOTS - 1));
            hi = TW'($urandom_range(lo, TIME_SLOTS - 1));
        end else begin
            lo = TW'($urandom);
            hi = TW'($urandom);
        end
    endtask

    initial begin
        logic [TW-1:0] st;
        logic [TW-1:0] en;
        int            round_no;
        int            n;
        int            i;
        bit            tight;

        answer_book  = new();
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_req_type   <= isrc_pkg::REQ_LOAD;
        i_start_time <= '0;
        i_end_time   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: empty table, edge fields, ignored loads, chained
        // intervals that share end points, unbuilt and stale tables.
        send_request(isrc_pkg::REQ_QUERY, 10'd1, 10'd1023);
        send_request(isrc_pkg::REQ_LOAD, 10'd1, 10'd2);
        send_request(isrc_pkg::REQ_LOAD, 10'd2, 10'd3);
        send_request(isrc_pkg::REQ_LOAD, 10'd3, 10'd4);
        send_request(isrc_pkg::REQ_LOAD, 10'd1022, 10'd1023);
        send_request(isrc_pkg::REQ_LOAD, 10'd1, 10'd1023);
        send_request(isrc_pkg::REQ_LOAD, 10'd0, 10'd50);
        send_request(isrc_pkg::REQ_LOAD, 10'd7, 10'd7);
        send_request(isrc_pkg::REQ_LOAD, 10'd900, 10'd10);
        send_request(isrc_pkg::REQ_QUERY, 10'd1, 10'd1023);
        send_request(isrc_pkg::REQ_BUILD, 10'd0, 10'd0);
        send_request(isrc_pkg::REQ_QUERY, 10'd1, 10'd1023);
        send_request(isrc_pkg::REQ_QUERY, 10'd0, 10'd1023);
        send_request(isrc_pkg::REQ_QUERY, 10'd2, 10'd3);
        send_request(isrc_pkg::REQ_QUERY, 10'd1023, 10'd1023);
        send_request(isrc_pkg::REQ_QUERY, 10'd1023, 10'd1);
        send_request(isrc_pkg::REQ_QUERY, 10'd0, 10'd0);
        send_request(isrc_pkg::REQ_LOAD, 10'd10, 10'd20);
        send_request(isrc_pkg::REQ_QUERY, 10'd0, 10'd1023);
        send_request(isrc_pkg::REQ_CLEAR, 10'd1023, 10'd1023);
        send_request(isrc_pkg::REQ_QUERY, 10'd1, 10'd1023);
        send_request(isrc_pkg::REQ_BUILD, 10'd1023, 10'd0);
        send_request(isrc_pkg::REQ_QUERY, 10'd1, 10'd1023);

        // Random rounds: optional clear, a batch of loads, usually a build,
        // then queries with a few loads mixed in. One round packs the line
        // with short intervals so that the high levels carry real jumps.
        round_no = 0;
        while (items_done < ITEM_GOAL) begin
            tight = (round_no == 2);
            if (tight || $urandom_range(0, 1) == 1) begin
                await_answers();
            end
            if (tight || $urandom_range(0, 1) == 1) begin
                send_request(isrc_pkg::REQ_CLEAR, TW'($urandom), TW'($urandom));
            end
            n = tight ? 400 : $urandom_range(20, 80);
            for (i = 0; i < n; i++) begin
                pick_interval(tight, st, en);
                send_request(isrc_pkg::REQ_LOAD, st, en);
            end
            if ($urandom_range(0, 3) == 0) begin
                pick_query(st, en);
                send_request(isrc_pkg::REQ_QUERY, st, en);
            end
            if (tight || $urandom_range(0, 7) != 0) begin
                send_request(isrc_pkg::REQ_BUILD, TW'($urandom), TW'($urandom));
            end
            n = $urandom_range(40, 100);
            for (i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    pick_interval(1'b0, st, en);
                    send_request(isrc_pkg::REQ_LOAD, st, en);
                end else begin
                    pick_query(st, en);
                    send_request(isrc_pkg::REQ_QUERY, st, en);
                end
            end
            round_no++;
        end

        // Drain, let a trailing load finish, then report.
        await_answers();
        repeat (20) @(posedge i_clk);
        if (answer_book.errors == 0) begin
            $display("** interval_schedule_range_count_top: PASSED **");
        end else begin
            $display("** interval_schedule_range_count_top: FAILED **");
        end
        $finish;
    end
endmodule

/* interval_schedule_range_count_top.f */
sv/isrc_pkg.sv
sv/isrc_ram.sv
sv/isrc_ctrl.sv
sv/isrc_dp.sv
sv/interval_schedule_range_count_top.sv
sim/interval_schedule_range_count_top_tb.sv
